/* src/telemetry_reply_line_parser_macros.svh */
// Assertion macros for the telemetry reply line parser top level.
`ifndef TELEMETRY_REPLY_LINE_PARSER_MACROS_SVH
`define TELEMETRY_REPLY_LINE_PARSER_MACROS_SVH

// Same-cycle implication, checked at every clock outside reset.
`define TRLP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock outside reset.
`define TRLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/trlp_pkg.sv */
// Types, character codes and reply-form tables for the telemetry reply line parser.
package trlp_pkg;

  // Reply forms, in the order of the msg_kind code
  typedef enum logic [2:0] {
    KIND_V  = 3'd0,
    KIND_T  = 3'd1,
    KIND_P  = 3'd2,
    KIND_BA = 3'd3,
    KIND_A  = 3'd4,
    KIND_DI = 3'd5
  } msg_kind_t;

  // Line result handed from the parser to the filter stage
  typedef struct packed {
    logic      valid;
    msg_kind_t kind;
    logic      good;
  } line_ctl_t;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_EQUAL = 8'h3D;
  localparam logic [7:0] CHAR_QUERY = 8'h3F;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_B     = 8'h42;
  localparam logic [7:0] CHAR_D     = 8'h44;
  localparam logic [7:0] CHAR_I     = 8'h49;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_V     = 8'h56;

  localparam logic [8:0]  ALPHA_RESET = 9'd13;
  localparam logic [8:0]  ALPHA_FULL  = 9'd256;
  localparam int          FILT_BITS   = 24;
  localparam logic [23:0] FILT_MAX    = 24'h7FFFFF;
  localparam logic [23:0] FILT_MIN    = 24'h800000;

  // Expected prefix character at a given position after the start letter
  function automatic logic [7:0] prefix_char(input msg_kind_t kind, input logic pos);
    logic [7:0] ch;
    ch = CHAR_EQUAL;
    if (!pos) begin
      if (kind == KIND_BA) ch = CHAR_A;
      else if (kind == KIND_DI) ch = CHAR_I;
    end
    return ch;
  endfunction

  // True when the prefix character at this position is the final one
  function automatic logic prefix_last(input msg_kind_t kind, input logic pos);
    return (kind == KIND_BA || kind == KIND_DI) ? pos : 1'b1;
  endfunction

  // Index of the final number field of a reply form
  function automatic logic [1:0] last_field(input msg_kind_t kind);
    logic [1:0] idx;
    idx = 2'd0;
    if (kind == KIND_V) idx = 2'd2;
    else if (kind == KIND_T) idx = 2'd1;
    return idx;
  endfunction

  function automatic logic is_space(input logic [7:0] ch);
    return ch == CHAR_SPACE || ch == CHAR_TAB || ch == CHAR_LF ||
           ch == CHAR_VT || ch == CHAR_FF;
  endfunction

endpackage

/* src/telemetry_reply_line_parser.sv */
// Top level of the telemetry reply line parser: byte stream in, parsed replies out.
//
// Usage:
//   s_tvalid/s_tready/s_tdata carry received text, one byte per word. A carriage
//   return ends a line; a line that selected a reply form yields one result word
//   on m_tvalid/m_tready/m_tdata/m_tuser, other bytes yield nothing.
//   cfg_we/cfg_wdata write the battery filter weight (1/256 units, above 256
//   acts as 256); write it only while the block is idle.
//   Throughput: one byte per cycle while s_tready is high. The line result
//   register, the filter product register and the output register form a
//   three-step path from an accepted carriage return to its result word.
//   The filter product register is loaded only when empty, so s_tready is low
//   in every cycle in which both the line result and the product stage are
//   occupied. With a ready receiver that never happens, since a reply line
//   takes at least two bytes.
//   When the receiver stalls, the output word holds; up to two more line
//   results queue behind it, and s_tready stays low once both are queued.
//   Reset (rst, synchronous) clears the line state, the battery filter and the
//   stop flag, sets the weight to 13 and empties all stages.
`include "telemetry_reply_line_parser_macros.svh"

module telemetry_reply_line_parser #(
  parameter int FIELD_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] rx_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // from bit 0: value_first, value_second, value_third, battery_filtered (24),
  // stop_active (1), zero fill
  output logic [((3 * FIELD_BITS + 25 + 7) / 8) * 8 - 1:0] m_tdata,
  output logic [3:0]   m_tuser,   // [2:0] msg_kind, [3] bad_parse
  input  logic         cfg_we,
  input  logic [8:0]   cfg_wdata  // battery_alpha
);
  import trlp_pkg::*;

  localparam int DATA_W = ((3 * FIELD_BITS + 25 + 7) / 8) * 8;
  localparam int DW     = ((FIELD_BITS + 8 > FILT_BITS) ? FIELD_BITS + 8 : FILT_BITS) + 1;
  localparam int PW     = DW + 10;
  localparam logic signed [PW-1:0] ROUND = PW'(128);
  localparam logic signed [PW-1:0] SAT_HI = PW'($signed(FILT_MAX));
  localparam logic signed [PW-1:0] SAT_LO = PW'($signed(FILT_MIN));

  logic [8:0]                   alpha;
  logic [8:0]                   alpha_eff;
  line_ctl_t                    r1;
  logic signed [FIELD_BITS-1:0] r1_first, r1_second, r1_third;
  logic                         s_fire, res_take;

  logic                         r2_valid;
  msg_kind_t                    r2_kind;
  logic                         r2_good;
  logic signed [FIELD_BITS-1:0] r2_first, r2_second, r2_third;
  logic signed [PW-1:0]         r2_prod;
  logic                         r2_adv;

  logic signed [DW-1:0]         diff;
  logic signed [PW-1:0]         prod;
  logic signed [PW-1:0]         filt_sum;
  logic signed [FILT_BITS-1:0]  filt_new;

  logic signed [FILT_BITS-1:0]  filter;
  logic                         stop;
  msg_kind_t                    out_kind;
  logic                         out_bad;
  logic signed [FIELD_BITS-1:0] out_first, out_second, out_third;

  // Weight register
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= ALPHA_RESET;
    end else if (cfg_we) begin
      alpha <= cfg_wdata;
    end
  end

  // Handshake across the stages
  assign res_take = r1.valid && !r2_valid;
  assign s_tready = !(r1.valid && r2_valid);
  assign s_fire   = s_tvalid && s_tready;
  assign r2_adv   = r2_valid && (!m_tvalid || m_tready);

  trlp_line_parser #(
    .FIELD_BITS(FIELD_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_fire  (s_fire),
    .byte_data  (s_tdata),
    .res_take   (res_take),
    .res        (r1),
    .res_first  (r1_first),
    .res_second (r1_second),
    .res_third  (r1_third)
  );

  // Filter product: weight times (new sample scaled by 256 minus the state)
  always_comb begin
    alpha_eff = (alpha > ALPHA_FULL) ? ALPHA_FULL : alpha;
    diff = $signed({{(DW - FIELD_BITS - 8){r1_second[FIELD_BITS-1]}}, r1_second, 8'h00})
         - $signed({{(DW - FILT_BITS){filter[FILT_BITS-1]}}, filter});
    prod = $signed({1'b0, alpha_eff}) * diff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_valid <= 1'b0;
    end else if (res_take) begin
      r2_valid <= 1'b1;
    end else if (r2_adv) begin
      r2_valid <= 1'b0;
    end
    if (res_take) begin
      r2_kind   <= r1.kind;
      r2_good   <= r1.good;
      r2_first  <= r1_first;
      r2_second <= r1_second;
      r2_third  <= r1_third;
      r2_prod   <= prod;
    end
  end

  // Filter update: state plus rounded, floored step, clamped to 24 bits
  always_comb begin
    filt_sum = $signed({{(PW - FILT_BITS){filter[FILT_BITS-1]}}, filter})
             + ((r2_prod + ROUND) >>> 8);
    if (filt_sum > SAT_HI) filt_new = $signed(FILT_MAX);
    else if (filt_sum < SAT_LO) filt_new = $signed(FILT_MIN);
    else filt_new = filt_sum[FILT_BITS-1:0];
  end

  // Output word, filter state and stop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      filter   <= '0;
      stop     <= 1'b0;
    end else begin
      if (r2_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (r2_adv && r2_good && r2_kind == KIND_V) begin
        filter <= filt_new;
      end
      if (r2_adv && r2_good && r2_kind == KIND_DI) begin
        stop <= r2_first != FIELD_BITS'(1);
      end
    end
    if (r2_adv) begin
      out_kind   <= r2_kind;
      out_bad    <= !r2_good;
      out_first  <= r2_first;
      out_second <= r2_second;
      out_third  <= r2_third;
    end
  end

  assign m_tdata = DATA_W'({stop, filter, out_third, out_second, out_first});
  assign m_tuser = {out_bad, out_kind};

  `TRLP_ASSERT_NEXT(a_filter_only_on_voltage,
      !(r2_adv && r2_good && r2_kind == KIND_V), $stable(filter),
      "battery filter moved without a good voltage reply")
  `TRLP_ASSERT_NEXT(a_stop_only_on_di,
      !(r2_adv && r2_good && r2_kind == KIND_DI), $stable(stop),
      "stop flag moved without a good DI reply")
  `TRLP_ASSERT_IMPL(a_bad_has_zero_values, m_tvalid && out_bad,
      out_first == '0 && out_second == '0 && out_third == '0,
      "bad parse word carries nonzero values")

endmodule

/* src/trlp_line_parser.sv */
// Per-byte line parser: tracks the reply form and numbers, registers one line result.
module trlp_line_parser #(
  parameter int FIELD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         byte_fire,
  input  logic [7:0]                   byte_data,
  input  logic                         res_take,
  output trlp_pkg::line_ctl_t          res,
  output logic signed [FIELD_BITS-1:0] res_first,
  output logic signed [FIELD_BITS-1:0] res_second,
  output logic signed [FIELD_BITS-1:0] res_third
);
  import trlp_pkg::*;

  localparam int AW = FIELD_BITS + 1;
  localparam int XW = FIELD_BITS + 5;
  localparam logic [XW-1:0] LIM = XW'(1) << (FIELD_BITS - 1);

  typedef enum logic [2:0] {
    PH_HUNT, PH_PREFIX, PH_PRENUM, PH_SIGN, PH_DIGITS, PH_DONE, PH_ECHO
  } phase_t;

  phase_t                  phase, phase_next;
  msg_kind_t               kind, kind_next;
  logic                    pos, pos_next;
  logic [1:0]              idx, idx_next;
  logic                    neg, neg_next;
  logic [AW-1:0]           acc, acc_next;
  logic                    line_bad, line_bad_next;
  logic [FIELD_BITS-1:0]   vals [3];
  logic [FIELD_BITS-1:0]   vals_next [3];
  logic [FIELD_BITS-1:0]   vals_fin [3];
  logic [FIELD_BITS-1:0]   fin;
  logic [XW-1:0]           acc_ext, acc_mul;
  logic [AW-1:0]           acc_sat;
  logic                    is_digit;
  logic                    res_load, res_good;
  logic [FIELD_BITS-1:0]   res_vals [3];

  // Digit accumulate with magnitude clamp
  always_comb begin
    is_digit = byte_data >= CHAR_ZERO && byte_data <= CHAR_NINE;
    acc_ext  = XW'(acc);
    acc_mul  = (acc_ext << 3) + (acc_ext << 1) + XW'(byte_data - CHAR_ZERO);
    acc_sat  = (acc_mul > LIM) ? LIM[AW-1:0] : acc_mul[AW-1:0];
  end

  // Close the current number: negate, or clamp to the positive limit
  always_comb begin
    if (neg) fin = -acc[FIELD_BITS-1:0];
    else if (acc >= LIM[AW-1:0]) fin = LIM[FIELD_BITS-1:0] - FIELD_BITS'(1);
    else fin = acc[FIELD_BITS-1:0];
    vals_fin = vals;
    if (idx == 2'd0) vals_fin[0] = fin;
    else if (idx == 2'd1) vals_fin[1] = fin;
    else vals_fin[2] = fin;
  end

  // Next line state and line result
  always_comb begin
    phase_next    = phase;
    kind_next     = kind;
    pos_next      = pos;
    idx_next      = idx;
    neg_next      = neg;
    acc_next      = acc;
    line_bad_next = line_bad;
    vals_next     = vals;
    res_load      = 1'b0;
    res_good      = 1'b0;
    for (int i = 0; i < 3; i++) res_vals[i] = '0;

    if (byte_fire) begin
      if (byte_data == CHAR_CR) begin
        if (phase != PH_HUNT && phase != PH_ECHO) begin
          res_load = 1'b1;
          if (phase == PH_DIGITS) begin
            res_good = idx >= last_field(kind);
            if (res_good) res_vals = vals_fin;
          end else begin
            res_good = (phase == PH_DONE) && !line_bad;
            if (res_good) res_vals = vals;
          end
        end
        // Clear for the next line
        phase_next    = PH_HUNT;
        kind_next     = KIND_V;
        pos_next      = 1'b0;
        idx_next      = 2'd0;
        neg_next      = 1'b0;
        acc_next      = '0;
        line_bad_next = 1'b0;
        for (int i = 0; i < 3; i++) vals_next[i] = '0;
      end else begin
        unique case (phase)
          PH_HUNT: begin
            priority if (byte_data == CHAR_V) begin
              kind_next = KIND_V; phase_next = PH_PREFIX; pos_next = 1'b0;
            end else if (byte_data == CHAR_T) begin
              kind_next = KIND_T; phase_next = PH_PREFIX; pos_next = 1'b0;
            end else if (byte_data == CHAR_P) begin
              kind_next = KIND_P; phase_next = PH_PREFIX; pos_next = 1'b0;
            end else if (byte_data == CHAR_B) begin
              kind_next = KIND_BA; phase_next = PH_PREFIX; pos_next = 1'b0;
            end else if (byte_data == CHAR_A) begin
              kind_next = KIND_A; phase_next = PH_PREFIX; pos_next = 1'b0;
            end else if (byte_data == CHAR_D) begin
              kind_next = KIND_DI; phase_next = PH_PREFIX; pos_next = 1'b0;
            end else if (byte_data == CHAR_QUERY) begin
              phase_next = PH_ECHO;
            end else begin
              phase_next = PH_HUNT;
            end
          end
          PH_PREFIX: begin
            if (byte_data != prefix_char(kind, pos)) begin
              line_bad_next = 1'b1;
              phase_next    = PH_DONE;
            end else if (prefix_last(kind, pos)) begin
              idx_next   = 2'd0;
              neg_next   = 1'b0;
              acc_next   = '0;
              phase_next = PH_PRENUM;
            end else begin
              pos_next = 1'b1;
            end
          end
          PH_PRENUM: begin
            priority if (is_space(byte_data)) begin
              phase_next = PH_PRENUM;
            end else if (byte_data == CHAR_PLUS || byte_data == CHAR_MINUS) begin
              neg_next   = byte_data == CHAR_MINUS;
              phase_next = PH_SIGN;
            end else if (is_digit) begin
              acc_next   = acc_sat;
              phase_next = PH_DIGITS;
            end else begin
              line_bad_next = 1'b1;
              phase_next    = PH_DONE;
            end
          end
          PH_SIGN: begin
            if (is_digit) begin
              acc_next   = acc_sat;
              phase_next = PH_DIGITS;
            end else begin
              line_bad_next = 1'b1;
              phase_next    = PH_DONE;
            end
          end
          PH_DIGITS: begin
            if (is_digit) begin
              acc_next = acc_sat;
            end else begin
              vals_next = vals_fin;
              if (idx < last_field(kind)) begin
                if (byte_data == CHAR_COLON) begin
                  idx_next   = idx + 2'd1;
                  neg_next   = 1'b0;
                  acc_next   = '0;
                  phase_next = PH_PRENUM;
                end else begin
                  line_bad_next = 1'b1;
                  phase_next    = PH_DONE;
                end
              end else begin
                phase_next = PH_DONE;
              end
            end
          end
          PH_DONE, PH_ECHO: begin
            phase_next = phase;
          end
          default: begin
            phase_next = PH_HUNT;
          end
        endcase
      end
    end
  end

  // Hold line state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HUNT;
      kind     <= KIND_V;
      pos      <= 1'b0;
      idx      <= 2'd0;
      neg      <= 1'b0;
      acc      <= '0;
      line_bad <= 1'b0;
      for (int i = 0; i < 3; i++) vals[i] <= '0;
    end else begin
      phase    <= phase_next;
      kind     <= kind_next;
      pos      <= pos_next;
      idx      <= idx_next;
      neg      <= neg_next;
      acc      <= acc_next;
      line_bad <= line_bad_next;
      vals     <= vals_next;
    end
  end

  // Register the line result until the filter stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (res_load) begin
      res.valid <= 1'b1;
    end else if (res_take) begin
      res.valid <= 1'b0;
    end
    if (res_load) begin
      res.kind   <= kind;
      res.good   <= res_good;
      res_first  <= res_vals[0];
      res_second <= res_vals[1];
      res_third  <= res_vals[2];
    end
  end

endmodule

/* tb/sv/telemetry_reply_line_parser_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for the telemetry reply line parser: reply text in, parsed reply words checked.
module telemetry_reply_line_parser_test;
  import trlp_pkg::*;

  localparam int VALUE_BITS   = 16;
  localparam int WORD_BITS    = ((3 * VALUE_BITS + 25 + 7) / 8) * 8;
  localparam int MAG_LIMIT    = 1 << (VALUE_BITS - 1);
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_BYTES  = 255;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_LIMIT  = 40;

  typedef enum logic [2:0] {
    SCAN_HUNT, SCAN_PREFIX, SCAN_PRENUM, SCAN_SIGN, SCAN_DIGITS, SCAN_DONE, SCAN_ECHO
  } scan_phase_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    msg_kind_t   kind;
    logic        bad;
    logic [15:0] first;
    logic [15:0] second;
    logic [15:0] third;
    logic [23:0] battery;
    logic        stop;
  } reply_t;

  // Line parser state mirror plus the queue of reply words still owed by the block
  class reply_scoreboard;
    scan_phase_t phase;
    msg_kind_t   kind;
    int          prefix_pos;
    int          field_idx;
    bit          negative;
    int          magnitude;
    int          fields[3];
    bit          line_bad;
    longint      battery;
    bit          stop;
    int          alpha;
    reply_t      expected_replies[$];
    int          mismatches;

    function new();
      alpha      = int'(ALPHA_RESET);
      battery    = 0;
      stop       = 0;
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      phase      = SCAN_HUNT;
      kind       = KIND_V;
      prefix_pos = 0;
      field_idx  = 0;
      negative   = 0;
      magnitude  = 0;
      fields     = '{0, 0, 0};
      line_bad   = 0;
    endfunction

    function int field_total();
      case (kind)
        KIND_V:  return 3;
        KIND_T:  return 2;
        default: return 1;
      endcase
    endfunction

    function void start_reply(msg_kind_t k);
      kind       = k;
      prefix_pos = 0;
      phase      = SCAN_PREFIX;
    endfunction

    function void mark_bad();
      line_bad = 1;
      phase    = SCAN_DONE;
    endfunction

    // Saturate the accumulated magnitude into the current field slot
    function void store_number();
      int v;
      if (negative) v = -magnitude;
      else v = (magnitude >= MAG_LIMIT) ? MAG_LIMIT - 1 : magnitude;
      fields[(field_idx > 2) ? 2 : field_idx] = v;
    endfunction

    // Advance the line state by one accepted word; a carriage return may owe a reply
    function void note_byte(logic [7:0] c);
      reply_t     r;
      bit         good;
      bit         digit;
      logic [7:0] want;
      longint     weight;
      longint     sum;
      digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      if (c == CHAR_CR) begin
        if (phase == SCAN_HUNT || phase == SCAN_ECHO) begin
          clear_line();
          return;
        end
        if (phase == SCAN_DIGITS) begin
          store_number();
          good = !line_bad && (field_idx + 1 >= field_total());
        end else begin
          good = (phase == SCAN_DONE) && !line_bad;
        end
        // Fold the battery voltage into the filter, or latch the stop switch
        if (good && kind == KIND_V) begin
          weight  = (alpha > 256) ? 256 : alpha;
          sum     = weight * fields[1] * 256 + (256 - weight) * battery + 128;
          battery = sum >>> 8;
          if (battery > 64'sd8388607) battery = 64'sd8388607;
          if (battery < -64'sd8388608) battery = -64'sd8388608;
        end else if (good && kind == KIND_DI) begin
          stop = (fields[0] != 1);
        end
        r.kind    = kind;
        r.bad     = !good;
        r.first   = good ? 16'(fields[0]) : 16'd0;
        r.second  = good ? 16'(fields[1]) : 16'd0;
        r.third   = good ? 16'(fields[2]) : 16'd0;
        r.battery = 24'(battery);
        r.stop    = stop;
        expected_replies.push_back(r);
        clear_line();
        return;
      end
      case (phase)
        SCAN_HUNT: begin
          case (c)
            CHAR_V:     start_reply(KIND_V);
            CHAR_T:     start_reply(KIND_T);
            CHAR_P:     start_reply(KIND_P);
            CHAR_B:     start_reply(KIND_BA);
            CHAR_A:     start_reply(KIND_A);
            CHAR_D:     start_reply(KIND_DI);
            CHAR_QUERY: phase = SCAN_ECHO;
            default: ;
          endcase
        end
        SCAN_PREFIX: begin
          want = CHAR_EQUAL;
          if (prefix_pos == 0 && kind == KIND_BA) want = CHAR_A;
          if (prefix_pos == 0 && kind == KIND_DI) want = CHAR_I;
          if (prefix_pos >= 2 || c != want) begin
            mark_bad();
          end else begin
            prefix_pos++;
            if (prefix_pos >= ((kind == KIND_BA || kind == KIND_DI) ? 2 : 1)) begin
              field_idx = 0;
              negative  = 0;
              magnitude = 0;
              phase     = SCAN_PRENUM;
            end
          end
        end
        SCAN_PRENUM, SCAN_SIGN, SCAN_DIGITS: begin
          // Skip blanks and take an optional sign before the first digit
          if (phase == SCAN_PRENUM) begin
            if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_VT ||
                c == CHAR_FF) return;
            if (c == CHAR_PLUS || c == CHAR_MINUS) begin
              negative = (c == CHAR_MINUS);
              phase    = SCAN_SIGN;
              return;
            end
          end
          if (phase != SCAN_DIGITS) begin
            if (!digit) begin
              mark_bad();
              return;
            end
            phase = SCAN_DIGITS;
          end
          if (digit) begin
            magnitude = magnitude * 10 + int'(c - CHAR_ZERO);
            if (magnitude > MAG_LIMIT) magnitude = MAG_LIMIT;
            return;
          end
          // A non-digit closes the number; only a colon opens the next field
          store_number();
          if (field_idx + 1 < field_total()) begin
            if (c == CHAR_COLON) begin
              field_idx++;
              negative  = 0;
              magnitude = 0;
              phase     = SCAN_PRENUM;
            end else begin
              mark_bad();
            end
          end else begin
            phase = SCAN_DONE;
          end
        end
        default: ;
      endcase
    endfunction

    task report(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
        $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
    endtask

    // Compare one accepted reply word against the oldest owed reply
    task check_reply(logic [WORD_BITS-1:0] data, logic [3:0] user);
      reply_t r;
      if (expected_replies.size() == 0) begin
        report("reply word with none owed", 0, longint'(data[63:0]));
        return;
      end
      r = expected_replies.pop_front();
      if (user[2:0] != r.kind) report("msg_kind", r.kind, user[2:0]);
      if (user[3] != r.bad) report("bad_parse", r.bad, user[3]);
      if (data[0 +: VALUE_BITS] != r.first)
        report("value_first", r.first, data[0 +: VALUE_BITS]);
      if (data[VALUE_BITS +: VALUE_BITS] != r.second)
        report("value_second", r.second, data[VALUE_BITS +: VALUE_BITS]);
      if (data[2 * VALUE_BITS +: VALUE_BITS] != r.third)
        report("value_third", r.third, data[2 * VALUE_BITS +: VALUE_BITS]);
      if (data[3 * VALUE_BITS +: 24] != r.battery)
        report("battery_filtered", r.battery, data[3 * VALUE_BITS +: 24]);
      if (data[3 * VALUE_BITS + 24] != r.stop)
        report("stop_active", r.stop, data[3 * VALUE_BITS + 24]);
      if (data[WORD_BITS-1:3 * VALUE_BITS + 25] != '0)
        report("zero fill", 0, longint'(data[WORD_BITS-1:3 * VALUE_BITS + 25]));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = 8'd0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [WORD_BITS-1:0] m_tdata;
  logic [3:0]           m_tuser;
  logic                 cfg_we = 1'b0;
  logic [8:0]           cfg_wdata = 9'd0;

  reply_scoreboard sb;
  idle_mode_t      idle_mode = IDLE_NONE;
  logic [7:0]      line_text[$];
  int              bytes_sent = 0;
  int              quiet_cycles = 0;

  always #5 clk = ~clk;

  telemetry_reply_line_parser #(
    .FIELD_BITS(VALUE_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Check accepted reply words and pick the next ready level
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_reply(m_tdata, m_tuser);
    case (idle_mode)
      IDLE_RECEIVER: m_tready <= ($urandom_range(0, 99) >= 79);
      IDLE_BOTH:     m_tready <= ($urandom_range(0, 99) >= 15);
      default:       m_tready <= 1'b1;
    endcase
  end

  // Give up when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void add(string s);
    foreach (s[i]) line_text.push_back(s[i]);
  endfunction

  // Any byte but carriage return; before the start letter, no start letter or question mark either
  function automatic logic [7:0] junk_byte(bit before_letter);
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CHAR_CR || (before_letter &&
               (b == CHAR_V || b == CHAR_T || b == CHAR_P || b == CHAR_B ||
                b == CHAR_A || b == CHAR_D || b == CHAR_QUERY)));
    return b;
  endfunction

  // Append one decimal field: optional blanks, optional sign, digits of varied size
  function automatic void add_number(bit stop_value);
    int         mode;
    int         mag;
    logic [7:0] blanks[5];
    blanks = '{CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF};
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 2)) line_text.push_back(blanks[$urandom_range(0, 4)]);
    if (stop_value && $urandom_range(0, 1) == 0) begin
      add($sformatf("%0d", $urandom_range(0, 1)));
      return;
    end
    case ($urandom_range(0, 3))
      0: line_text.push_back(CHAR_MINUS);
      1: line_text.push_back(CHAR_PLUS);
      default: ;
    endcase
    mode = $urandom_range(0, 9);
    if (mode == 8) begin
      repeat ($urandom_range(6, 12)) line_text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      return;
    end
    case (mode)
      5, 6:    mag = $urandom_range(0, 99999);
      7:       mag = MAG_LIMIT - 1 + $urandom_range(0, 2);
      9: begin
        repeat ($urandom_range(1, 4)) line_text.push_back(CHAR_ZERO);
        mag = $urandom_range(0, 99);
      end
      default: mag = $urandom_range(0, 999);
    endcase
    add($sformatf("%0d", mag));
  endfunction

  // Push every queued byte through the slave side, idling as the phase asks
  task automatic send_line();
    int gap;
    foreach (line_text[i]) begin
      gap = 0;
      if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH)
        while ($urandom_range(0, 99) < ((idle_mode == IDLE_SENDER) ? 79 : 15)) gap++;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= line_text[i];
      do @(posedge clk); while (!s_tready);
      sb.note_byte(line_text[i]);
      bytes_sent++;
    end
    line_text.delete();
  endtask

  task automatic send_text(string s);
    add(s);
    line_text.push_back(CHAR_CR);
    send_line();
  endtask

  // Mostly well-formed replies with random numbers; some echoes, letterless and broken lines
  task automatic random_line();
    int        r;
    int        idx;
    msg_kind_t k;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) line_text.push_back(junk_byte(1'b1));
    if (r < 8) begin
      line_text.push_back(CHAR_QUERY);
      if (r < 4) add("DI=0");
      else repeat ($urandom_range(0, 4)) line_text.push_back(junk_byte(1'b0));
    end else if (r < 14) begin
      repeat ($urandom_range(0, 4)) line_text.push_back(junk_byte(1'b1));
    end else begin
      k = msg_kind_t'(3'($urandom_range(0, 5)));
      case (k)
        KIND_V:  add("V=");
        KIND_T:  add("T=");
        KIND_P:  add("P=");
        KIND_BA: add("BA=");
        KIND_A:  add("A=");
        default: add("DI=");
      endcase
      for (int i = 0; i < ((k == KIND_V) ? 3 : (k == KIND_T) ? 2 : 1); i++) begin
        if (i > 0) line_text.push_back(CHAR_COLON);
        add_number(k == KIND_DI);
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) line_text.push_back(junk_byte(1'b0));
      // Corrupt, drop or cut off part of the line
      if (r >= 86) begin
        idx = $urandom_range(0, line_text.size() - 1);
        case ($urandom_range(0, 2))
          0:       line_text[idx] = junk_byte(1'b0);
          1:       line_text.delete(idx);
          default: while (line_text.size() > idx) void'(line_text.pop_back());
        endcase
      end
    end
    if ($urandom_range(0, 19) != 0) line_text.push_back(CHAR_CR);
    send_line();
  endtask

  // Hold until every owed reply is out, then let the pipeline settle
  task automatic wait_idle();
    while (sb.expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [8:0] alphas[4];
    idle_mode_t modes[4];
    int         target;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed lines at the reset filter weight
    send_text("V=120:245:12500");
    send_text("T=-40:+85");
    send_text("P=32767");
    send_text("P=32768");
    send_text("BA=-32768");
    send_text("BA=-32769");
    send_text("A=99999999999");
    send_text("A=+0:junk");
    send_text("DI=1");
    send_text("DI=0");
    send_text("DI=-1");
    send_text("?V=1:2:3");
    send_text("hello");
    send_text("");
    send_text("V=1:2");
    send_text("BX=5");
    send_text("D=1");
    send_text("T=5;6");
    send_text("P=");
    send_text("P=-");
    send_text("V=-7:30000:+4");
    line_text.push_back(8'h00);
    line_text.push_back(8'hFF);
    add("A=");
    line_text.push_back(CHAR_TAB);
    line_text.push_back(CHAR_VT);
    line_text.push_back(CHAR_FF);
    line_text.push_back(CHAR_LF);
    add(" 7 trailing");
    line_text.push_back(CHAR_CR);
    send_line();

    // Random phases, each with its own filter weight and idling pattern
    alphas = '{9'd0, 9'd256, 9'd511, 9'($urandom_range(1, 255))};
    modes  = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
    for (int p = 0; p < 4; p++) begin
      s_tvalid <= 1'b0;
      wait_idle();
      cfg_we    <= 1'b1;
      cfg_wdata <= alphas[p];
      idle_mode <= modes[p];
      @(posedge clk);
      cfg_we   <= 1'b0;
      sb.alpha = int'(alphas[p]);
      target   = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) random_line();
    end

    s_tvalid <= 1'b0;
    wait_idle();
    if (sb.mismatches == 0 && sb.expected_replies.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* telemetry_reply_line_parser.f */
+incdir+src
src/trlp_pkg.sv
src/trlp_line_parser.sv
src/telemetry_reply_line_parser.sv
tb/sv/telemetry_reply_line_parser_test.sv
